// ----- src/assert_macros.svh -----
// Assertion macros shared by the RTL of the block multiply-accumulate unit.
// No dependencies; expects clk and arst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// checked outside reset only
`define AST_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// checked at every edge, reset included
`define AST_ANY(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define AST_CLK(lbl, prop, msg)
`define AST_ANY(lbl, prop, msg)
`endif
`endif

// ----- src/mma_pkg.sv -----
// Shared types, constants and index helpers of the block multiply-accumulate unit.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mma_pkg;

	localparam int DIM   = 8;
	localparam int DW    = 64;
	localparam int DEPTH = DIM * DIM;
	localparam int CRD_W = $clog2(DIM);
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CHK_W = $clog2(DIM + 16) + 1;

	localparam logic [2:0] CMD_WR_A = 3'd0;
	localparam logic [2:0] CMD_WR_B = 3'd1;
	localparam logic [2:0] CMD_WR_C = 3'd2;
	localparam logic [2:0] CMD_MAC  = 3'd3;
	localparam logic [2:0] CMD_RD_C = 3'd4;

	typedef struct packed {
		logic [2:0]    command;
		logic [2:0]    elem_row;
		logic [2:0]    elem_col;
		logic [DW-1:0] write_value;
		logic [2:0]    a_row_base;
		logic [2:0]    a_col_base;
		logic [2:0]    b_row_base;
		logic [2:0]    b_col_base;
		logic [2:0]    c_row_base;
		logic [2:0]    c_col_base;
		logic [3:0]    block_size;
	} mma_cmd_t;

	typedef struct packed {
		logic [DW-1:0] read_data;
		logic          status;
	} mma_rsp_t;

	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] addr;
		logic [DW-1:0]    data;
	} mma_wport_t;

	// control carried alongside each issued product
	typedef struct packed {
		logic             vld;
		logic             first;
		logic             last;
		logic [IDX_W-1:0] caddr;
	} mma_tag_t;

	function automatic logic [IDX_W-1:0] mma_idx(input logic [CRD_W-1:0] r,
		input logic [CRD_W-1:0] c);
		mma_idx = IDX_W'(r * DIM + c);
	endfunction

	function automatic logic mma_fits(input logic [2:0] base, input logic [3:0] n);
		mma_fits = (CHK_W'(base) + CHK_W'(n)) <= CHK_W'(DIM);
	endfunction

	function automatic logic mma_in_range(input logic [2:0] v);
		mma_in_range = CHK_W'(v) < CHK_W'(DIM);
	endfunction

endpackage

`default_nettype wire

// ----- src/mma_ram.sv -----
// Generic one-write, one-read synchronous RAM with registered read data.
// Per-entry valid bits make unwritten entries read as zero after reset.
`timescale 1ns / 1ps
`default_nettype none

module mma_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [DEPTH-1:0] vld_q;
	logic [WIDTH-1:0] rd_q;
	logic             hit_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			hit_q <= 1'b0;
		end else begin
			hit_q <= vld_q[raddr];
			if (we) begin
				vld_q[waddr] <= 1'b1;
			end
		end
	end

	assign rdata = hit_q ? rd_q : '0;

endmodule

`default_nettype wire

// ----- src/mma_mac.sv -----
// Multiply-accumulate datapath: split 64-bit product, accumulator, C write-back.
// Depends on mma_pkg; operands arrive in the cycle after the tag is issued.
`timescale 1ns / 1ps
`default_nettype none

module mma_mac import mma_pkg::*; (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire mma_tag_t      tag,
	input  wire logic [DW-1:0] a_data,
	input  wire logic [DW-1:0] b_data,
	input  wire logic [DW-1:0] c_data,
	output mma_wport_t         wb,
	output logic               pipe_busy
);

	mma_tag_t      tag_s1, tag_s2, tag_s3;
	logic [DW-1:0] ll_s2;
	logic [31:0]   x_s2;
	logic [DW-1:0] c_s2, c_s3;
	logic [DW-1:0] prod_s3;
	logic [DW-1:0] acc_q;
	logic [DW-1:0] acc_sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
			tag_s3 <= '0;
		end else begin
			tag_s1 <= tag;
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
		end
	end

	// low half products; the high cross terms only feed bits 63:32
	always_ff @(posedge clk) begin
		ll_s2   <= DW'(a_data[31:0]) * DW'(b_data[31:0]);
		x_s2    <= 32'(a_data[31:0] * b_data[63:32]) + 32'(a_data[63:32] * b_data[31:0]);
		c_s2    <= c_data;
		prod_s3 <= ll_s2 + {x_s2, 32'd0};
		c_s3    <= c_s2;
		if (tag_s3.vld) begin
			acc_q <= acc_sum;
		end
	end

	assign acc_sum   = (tag_s3.first ? c_s3 : acc_q) + prod_s3;
	assign wb.we     = tag_s3.vld & tag_s3.last;
	assign wb.addr   = tag_s3.caddr;
	assign wb.data   = acc_sum;
	assign pipe_busy = tag_s1.vld | tag_s2.vld | tag_s3.vld;

endmodule

`default_nettype wire

// ----- src/mma_ctrl.sv -----
// Command decoder and block sequencer: drives the A, B and C memory ports.
// Depends on mma_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module mma_ctrl import mma_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire mma_cmd_t         cmd,
	output logic                  busy,
	output logic                  done,
	output mma_rsp_t              rsp,
	output mma_wport_t            a_wr,
	output mma_wport_t            b_wr,
	output mma_wport_t            c_wr,
	output logic      [IDX_W-1:0] a_raddr,
	output logic      [IDX_W-1:0] b_raddr,
	output logic      [IDX_W-1:0] c_raddr,
	input  wire logic [DW-1:0]    c_rdata,
	output mma_tag_t              tag,
	input  wire logic             pipe_busy
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_RDWAIT,
		ST_ISSUE,
		ST_DRAIN
	} state_t;

	state_t           state_q;
	mma_cmd_t         cmd_q;
	mma_rsp_t         rsp_q;
	logic             done_q;
	logic [CRD_W-1:0] i_q, j_q, k_q, nm1_q;

	logic             ok;
	logic             fits;
	logic [IDX_W-1:0] eidx, aidx, bidx, cidx;
	logic [CRD_W-1:0] ar, ac, br, bc, cr, cc;
	logic             k_end, j_end, i_end;

	assign ok   = mma_in_range(cmd_q.elem_row) & mma_in_range(cmd_q.elem_col);
	assign eidx = mma_idx(CRD_W'(cmd_q.elem_row), CRD_W'(cmd_q.elem_col));
	assign fits = mma_fits(cmd_q.a_row_base, cmd_q.block_size)
		& mma_fits(cmd_q.a_col_base, cmd_q.block_size)
		& mma_fits(cmd_q.b_row_base, cmd_q.block_size)
		& mma_fits(cmd_q.b_col_base, cmd_q.block_size)
		& mma_fits(cmd_q.c_row_base, cmd_q.block_size)
		& mma_fits(cmd_q.c_col_base, cmd_q.block_size);

	assign ar = CRD_W'(cmd_q.a_row_base) + i_q;
	assign ac = CRD_W'(cmd_q.a_col_base) + k_q;
	assign br = CRD_W'(cmd_q.b_row_base) + k_q;
	assign bc = CRD_W'(cmd_q.b_col_base) + j_q;
	assign cr = CRD_W'(cmd_q.c_row_base) + i_q;
	assign cc = CRD_W'(cmd_q.c_col_base) + j_q;

	assign aidx = mma_idx(ar, ac);
	assign bidx = mma_idx(br, bc);
	assign cidx = mma_idx(cr, cc);

	assign k_end = k_q == nm1_q;
	assign j_end = j_q == nm1_q;
	assign i_end = i_q == nm1_q;

	assign a_raddr = aidx;
	assign b_raddr = bidx;
	assign c_raddr = (state_q == ST_ISSUE) ? cidx : eidx;

	assign a_wr.we   = (state_q == ST_EXEC) && (cmd_q.command == CMD_WR_A) && ok;
	assign a_wr.addr = eidx;
	assign a_wr.data = cmd_q.write_value;
	assign b_wr.we   = (state_q == ST_EXEC) && (cmd_q.command == CMD_WR_B) && ok;
	assign b_wr.addr = eidx;
	assign b_wr.data = cmd_q.write_value;
	assign c_wr.we   = (state_q == ST_EXEC) && (cmd_q.command == CMD_WR_C) && ok;
	assign c_wr.addr = eidx;
	assign c_wr.data = cmd_q.write_value;

	assign tag.vld   = state_q == ST_ISSUE;
	assign tag.first = k_q == '0;
	assign tag.last  = k_end;
	assign tag.caddr = cidx;

	assign busy = state_q != ST_IDLE;
	assign done = done_q;
	assign rsp  = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cmd_q   <= '0;
			rsp_q   <= '0;
			done_q  <= 1'b0;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
			nm1_q   <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						cmd_q   <= cmd;
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					case (cmd_q.command)
						CMD_RD_C: begin
							state_q <= ST_RDWAIT;
						end
						CMD_MAC: begin
							if (cmd_q.block_size == 4'd0) begin
								rsp_q   <= '0;
								done_q  <= 1'b1;
								state_q <= ST_IDLE;
							end else if (!fits) begin
								rsp_q.read_data <= '0;
								rsp_q.status    <= 1'b1;
								done_q          <= 1'b1;
								state_q         <= ST_IDLE;
							end else begin
								i_q     <= '0;
								j_q     <= '0;
								k_q     <= '0;
								nm1_q   <= CRD_W'(cmd_q.block_size - 4'd1);
								state_q <= ST_ISSUE;
							end
						end
						default: begin
							rsp_q   <= '0;
							done_q  <= 1'b1;
							state_q <= ST_IDLE;
						end
					endcase
				end
				ST_RDWAIT: begin
					rsp_q.read_data <= ok ? c_rdata : '0;
					rsp_q.status    <= 1'b0;
					done_q          <= 1'b1;
					state_q         <= ST_IDLE;
				end
				ST_ISSUE: begin
					if (!k_end) begin
						k_q <= k_q + 1'b1;
					end else begin
						k_q <= '0;
						if (!j_end) begin
							j_q <= j_q + 1'b1;
						end else begin
							j_q <= '0;
							if (!i_end) begin
								i_q <= i_q + 1'b1;
							end else begin
								state_q <= ST_DRAIN;
							end
						end
					end
				end
				ST_DRAIN: begin
					if (!pipe_busy) begin
						rsp_q   <= '0;
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`AST_CLK(a_done_pulse, done |=> !done, "result strobe held for more than one cycle")
	`AST_CLK(a_idle_drained, !busy |-> !pipe_busy, "idle while products still in flight")
	`AST_CLK(a_accept_busy, start && !busy |=> busy, "accepted word did not raise busy")
	`AST_CLK(a_done_idle, done |-> !busy, "result shown while still busy")
	`AST_ANY(a_reset_idle, !arst_n |=> !busy && !done, "block not idle in reset")

endmodule

`default_nettype wire

// ----- src/block_matrix_multiply_accumulate.sv -----
// Top level of the block multiply-accumulate unit: sequencer, MAC datapath, A/B/C RAMs.
// Depends on mma_pkg, mma_ram, mma_mac and mma_ctrl.
//
// Use: drive a command word on cmd and raise start; the word is taken at a rising
// edge where start is high and busy is low. Commands write an element of A, B or C,
// read an element of C, or add the product of an n-by-n block of A and B into a
// block of C (64-bit wrapping arithmetic).
// Each word gives exactly one result word on rsp, valid for the single cycle that
// done is high; the receiver has no way to stall it and must take it then.
// The block multiply issues one multiply-accumulate per cycle, set by the single read
// port of each matrix RAM; the 64-bit product is built in three pipeline stages.
// One word is processed at a time; busy stays high until its result is out.
// Reset clears all three matrices (per-entry valid bits, no clearing pass) and
// returns the unit to idle at once.
`timescale 1ns / 1ps
`default_nettype none

module block_matrix_multiply_accumulate import mma_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start,
	input  wire mma_cmd_t cmd,
	output logic          busy,
	output logic          done,
	output mma_rsp_t      rsp
);

	mma_wport_t       a_wr, b_wr, ctl_c_wr, wb, c_wport;
	logic [IDX_W-1:0] a_raddr, b_raddr, c_raddr;
	logic [DW-1:0]    a_rdata, b_rdata, c_rdata;
	mma_tag_t         tag;
	logic             pipe_busy;

	mma_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.cmd       (cmd),
		.busy      (busy),
		.done      (done),
		.rsp       (rsp),
		.a_wr      (a_wr),
		.b_wr      (b_wr),
		.c_wr      (ctl_c_wr),
		.a_raddr   (a_raddr),
		.b_raddr   (b_raddr),
		.c_raddr   (c_raddr),
		.c_rdata   (c_rdata),
		.tag       (tag),
		.pipe_busy (pipe_busy)
	);

	mma_mac u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.tag       (tag),
		.a_data    (a_rdata),
		.b_data    (b_rdata),
		.c_data    (c_rdata),
		.wb        (wb),
		.pipe_busy (pipe_busy)
	);

	// element writes and block write-back never overlap
	assign c_wport = wb.we ? wb : ctl_c_wr;

	mma_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_ram_a (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (a_wr.we),
		.waddr  (a_wr.addr),
		.wdata  (a_wr.data),
		.raddr  (a_raddr),
		.rdata  (a_rdata)
	);

	mma_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_ram_b (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (b_wr.we),
		.waddr  (b_wr.addr),
		.wdata  (b_wr.data),
		.raddr  (b_raddr),
		.rdata  (b_rdata)
	);

	mma_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_ram_c (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (c_wport.we),
		.waddr  (c_wport.addr),
		.wdata  (c_wport.data),
		.raddr  (c_raddr),
		.rdata  (c_rdata)
	);

endmodule

`default_nettype wire

// ----- sim/block_matrix_multiply_accumulate_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench of block_matrix_multiply_accumulate: directed and random command
// words, each result checked against a behavioural model of matrices A, B and C.
// Depends on mma_pkg and the RTL of the block.

module block_matrix_multiply_accumulate_tb;
	import mma_pkg::*;

	localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
	localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;
	localparam int         RANDOM_WORDS    = 1144;
	localparam longint     CYCLE_LIMIT     = 3_000_000;
	localparam int         DRAIN_CYCLES    = DIM * DIM * DIM + 8;
	localparam int         MAX_LOGGED      = 40;

	logic     clk    = 1'b0;
	logic     arst_n = 1'b0;
	logic     start  = 1'b0;
	mma_cmd_t cmd    = '0;
	logic     busy;
	logic     done;
	mma_rsp_t rsp;

	block_matrix_multiply_accumulate dut (
		.clk(clk), .arst_n(arst_n), .start(start), .cmd(cmd),
		.busy(busy), .done(done), .rsp(rsp)
	);

	logic [DW-1:0] mat_a [DEPTH];
	logic [DW-1:0] mat_b [DEPTH];
	logic [DW-1:0] mat_c [DEPTH];
	mma_rsp_t      rsp_due [$];

	int     errors     = 0;
	int     n_words    = 0;
	int     n_writes   = 0;
	int     n_reads    = 0;
	int     n_macs     = 0;
	int     n_rejected = 0;
	int     n_spare    = 0;
	int     n_checked  = 0;
	int     burst_left = 0;
	longint cycles     = 0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	task automatic report_mismatch(input string what);
		errors++;
		if (errors <= MAX_LOGGED)
			$display("MISMATCH cycle %0d: %s", cycles, what);
	endtask

	task automatic clear_matrices();
		for (int i = 0; i < DEPTH; i++) begin
			mat_a[i] = '0;
			mat_b[i] = '0;
			mat_c[i] = '0;
		end
	endtask

	// behavioural model: applies one word to the matrices and gives its result
	task automatic apply_word(input mma_cmd_t w, output mma_rsp_t r);
		int            idx;
		int            n;
		bit            in_mat;
		bit            fits;
		logic [DW-1:0] acc;
		r      = '0;
		in_mat = int'(w.elem_row) < DIM && int'(w.elem_col) < DIM;
		idx    = int'(w.elem_row) * DIM + int'(w.elem_col);
		n      = int'(w.block_size);
		case (w.command)
			CMD_WR_A: begin
				if (in_mat) mat_a[idx] = w.write_value;
				n_writes++;
			end
			CMD_WR_B: begin
				if (in_mat) mat_b[idx] = w.write_value;
				n_writes++;
			end
			CMD_WR_C: begin
				if (in_mat) mat_c[idx] = w.write_value;
				n_writes++;
			end
			CMD_RD_C: begin
				if (in_mat) r.read_data = mat_c[idx];
				n_reads++;
			end
			CMD_MAC: begin
				n_macs++;
				fits = int'(w.a_row_base) + n <= DIM && int'(w.a_col_base) + n <= DIM &&
					int'(w.b_row_base) + n <= DIM && int'(w.b_col_base) + n <= DIM &&
					int'(w.c_row_base) + n <= DIM && int'(w.c_col_base) + n <= DIM;
				if (n != 0 && !fits) begin
					r.status = 1'b1;
					n_rejected++;
				end else begin
					for (int i = 0; i < n; i++) begin
						for (int j = 0; j < n; j++) begin
							acc = mat_c[(int'(w.c_row_base) + i) * DIM + int'(w.c_col_base) + j];
							for (int k = 0; k < n; k++)
								acc += mat_a[(int'(w.a_row_base) + i) * DIM + int'(w.a_col_base) + k] *
									mat_b[(int'(w.b_row_base) + k) * DIM + int'(w.b_col_base) + j];
							mat_c[(int'(w.c_row_base) + i) * DIM + int'(w.c_col_base) + j] = acc;
						end
					end
				end
			end
			default: n_spare++;
		endcase
	endtask

	// sends one word in bursts with random gaps; start stays high inside a burst
	task automatic send_word(input mma_cmd_t w);
		mma_rsp_t r;
		int       gap;
		if (burst_left == 0) begin
			gap = $urandom_range(12, 1);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(4, 0) == 0) ? $urandom_range(100, 40)
				: $urandom_range(8, 1);
		end
		burst_left--;
		start <= 1'b1;
		cmd   <= w;
		do @(posedge clk); while (busy !== 1'b0);
		apply_word(w, r);
		rsp_due = {rsp_due, r};
		n_words++;
	endtask

	function automatic logic [DW-1:0] rand_value();
		case ($urandom_range(7, 0))
			0:       return '0;
			1:       return '1;
			2:       return {1'b1, {(DW - 1){1'b0}}};
			3:       return DW'($urandom_range(15, 0));
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic mma_cmd_t noise_word();
		mma_cmd_t w;
		w.command     = 3'($urandom_range(7, 0));
		w.elem_row    = 3'($urandom_range(7, 0));
		w.elem_col    = 3'($urandom_range(7, 0));
		w.write_value = {$urandom, $urandom};
		w.a_row_base  = 3'($urandom_range(7, 0));
		w.a_col_base  = 3'($urandom_range(7, 0));
		w.b_row_base  = 3'($urandom_range(7, 0));
		w.b_col_base  = 3'($urandom_range(7, 0));
		w.c_row_base  = 3'($urandom_range(7, 0));
		w.c_col_base  = 3'($urandom_range(7, 0));
		w.block_size  = 4'($urandom_range(15, 0));
		return w;
	endfunction

	function automatic mma_cmd_t elem_word(input logic [2:0] op, input int row, input int col,
		input logic [DW-1:0] value);
		mma_cmd_t w;
		w             = noise_word();
		w.command     = op;
		w.elem_row    = 3'(row);
		w.elem_col    = 3'(col);
		w.write_value = value;
		return w;
	endfunction

	function automatic mma_cmd_t mac_word(input int ar, input int ac, input int br, input int bc,
		input int cr, input int cc, input int n);
		mma_cmd_t w;
		w            = noise_word();
		w.command    = CMD_MAC;
		w.a_row_base = 3'(ar);
		w.a_col_base = 3'(ac);
		w.b_row_base = 3'(br);
		w.b_col_base = 3'(bc);
		w.c_row_base = 3'(cr);
		w.c_col_base = 3'(cc);
		w.block_size = 4'(n);
		return w;
	endfunction

	function automatic mma_cmd_t random_word();
		mma_cmd_t w;
		int       pick;
		int       sel;
		int       n;
		w    = noise_word();
		pick = $urandom_range(99, 0);
		if (pick < 42) begin
			case ($urandom_range(2, 0))
				0:       w.command = CMD_WR_A;
				1:       w.command = CMD_WR_B;
				default: w.command = CMD_WR_C;
			endcase
			w.write_value = rand_value();
		end else if (pick < 70) begin
			w.command = CMD_RD_C;
		end else if (pick < 95) begin
			w.command = CMD_MAC;
			sel       = $urandom_range(99, 0);
			if (sel < 6) begin
				w.block_size = '0;
			end else if (sel >= 14) begin
				// a block that fits; mostly small, now and then the whole matrix
				n            = (sel < 18) ? DIM : $urandom_range(4, 1);
				w.block_size = 4'(n);
				w.a_row_base = 3'($urandom_range(DIM - n, 0));
				w.a_col_base = 3'($urandom_range(DIM - n, 0));
				w.b_row_base = 3'($urandom_range(DIM - n, 0));
				w.b_col_base = 3'($urandom_range(DIM - n, 0));
				w.c_row_base = 3'($urandom_range(DIM - n, 0));
				w.c_col_base = 3'($urandom_range(DIM - n, 0));
			end
		end else begin
			w.command = 3'($urandom_range(int'(CMD_SPARE_LAST), int'(CMD_SPARE_FIRST)));
		end
		return w;
	endfunction

	task automatic test_element_access();
		send_word(elem_word(CMD_RD_C, 3, 4, '1));
		send_word(elem_word(CMD_WR_A, 0, 0, '1));
		send_word(elem_word(CMD_WR_B, 7, 7, '1));
		send_word(elem_word(CMD_WR_C, 0, 7, 64'h8000_0000_0000_0001));
		send_word(elem_word(CMD_RD_C, 0, 7, '0));
		send_word(elem_word(CMD_WR_C, 7, 7, '1));
		send_word(elem_word(CMD_RD_C, 7, 7, '0));
	endtask

	task automatic test_zero_block();
		send_word(mac_word(7, 7, 7, 7, 7, 7, 0));
		send_word(elem_word(CMD_RD_C, 7, 7, '0));
	endtask

	// all-ones squared wraps to one; corner block of one element
	task automatic test_wrapping_blocks();
		send_word(elem_word(CMD_WR_B, 0, 0, '1));
		send_word(mac_word(0, 0, 0, 0, 0, 0, DIM));
		send_word(elem_word(CMD_RD_C, 0, 0, '0));
		send_word(elem_word(CMD_WR_A, 7, 7, 64'd3));
		send_word(mac_word(7, 7, 7, 7, 7, 7, 1));
		send_word(elem_word(CMD_RD_C, 7, 7, '0));
	endtask

	task automatic test_edge_rejection();
		for (int s = 0; s < 6; s++)
			send_word(mac_word(s == 0 ? 7 : 0, s == 1 ? 7 : 0, s == 2 ? 7 : 0,
				s == 3 ? 7 : 0, s == 4 ? 7 : 0, s == 5 ? 7 : 0, 2));
		send_word(mac_word(0, 0, 0, 0, 0, 0, 15));
		send_word(elem_word(CMD_RD_C, 0, 0, '0));
	endtask

	task automatic test_spare_codes();
		for (int c = int'(CMD_SPARE_FIRST); c <= int'(CMD_SPARE_LAST); c++)
			send_word(elem_word(3'(c), $urandom_range(7, 0), $urandom_range(7, 0), '1));
	endtask

	task automatic test_random_traffic();
		for (int i = 0; i < RANDOM_WORDS; i++)
			send_word(random_word());
	endtask

	task automatic finish_run();
		start <= 1'b0;
		while (rsp_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("%0d words sent: %0d writes, %0d reads, %0d block MACs (%0d out of bounds), %0d spare",
			n_words, n_writes, n_reads, n_macs, n_rejected, n_spare);
		$display("%0d results compared, %0d mismatches, %0d cycles", n_checked, errors, cycles);
		if (errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	endtask

	always @(posedge clk) begin
		mma_rsp_t want;
		if (arst_n && done !== 1'b0) begin
			if (rsp_due.size() == 0) begin
				report_mismatch("result word with none expected");
			end else begin
				want = rsp_due.pop_front();
				n_checked++;
				if (rsp.read_data !== want.read_data)
					report_mismatch($sformatf("read_data %h, expected %h",
						rsp.read_data, want.read_data));
				if (rsp.status !== want.status)
					report_mismatch($sformatf("status %b, expected %b", rsp.status, want.status));
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles, rsp_due.size());
			$display("end of test: mismatches");
			$finish;
		end
	end

	initial begin
		clear_matrices();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_element_access();
		test_zero_block();
		test_wrapping_blocks();
		test_edge_rejection();
		test_spare_codes();
		test_random_traffic();
		finish_run();
	end

endmodule

// ----- sim.f -----
+incdir+src
src/mma_pkg.sv
src/mma_ram.sv
src/mma_mac.sv
src/mma_ctrl.sv
src/block_matrix_multiply_accumulate.sv
sim/block_matrix_multiply_accumulate_tb.sv
